/* hdl/formation_pursuit_controller_assert.svh */
// Assertion macros shared by the formation pursuit controller RTL
`ifndef FORMATION_PURSUIT_CONTROLLER_ASSERT_SVH
`define FORMATION_PURSUIT_CONTROLLER_ASSERT_SVH
// Same-cycle implication, sampled on clk, off during rst
`define FPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk, off during rst
`define FPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* hdl/fpc_pkg.sv */
// Types, constants and helper functions of the formation pursuit controller
package fpc_pkg;

  localparam int XW = 40;   // CORDIC x/y datapath
  localparam int ZW = 34;   // CORDIC angle accumulator
  localparam int MW = 34;   // multiplier operand
  localparam int PW = 68;   // multiplier product
  localparam int DW = 36;   // distance

  localparam logic [1:0] ACT_LEADER = 2'd0;
  localparam logic [1:0] ACT_OWN    = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] MODE_WAIT   = 2'd0;
  localparam logic [1:0] MODE_STALE  = 2'd1;
  localparam logic [1:0] MODE_ALIGN  = 2'd2;
  localparam logic [1:0] MODE_PURSUE = 2'd3;

  localparam logic [2:0] REG_TRAIL_OFS   = 3'd0;
  localparam logic [2:0] REG_LATERAL_OFS = 3'd1;
  localparam logic [2:0] REG_MAX_LINEAR  = 3'd2;
  localparam logic [2:0] REG_MAX_ANGULAR = 3'd3;
  localparam logic [2:0] REG_GAIN_LINEAR = 3'd4;
  localparam logic [2:0] REG_GAIN_ANG    = 3'd5;
  localparam logic [2:0] REG_ARRIVE      = 3'd6;
  localparam logic [2:0] REG_STALE       = 3'd7;

  localparam logic signed [XW-1:0] INV_K_Q30 = XW'(652032875);
  localparam logic signed [MW-1:0] INV_K_Q24 = MW'(10188014);
  localparam logic signed [MW-1:0] TWO_PI_Q16 = MW'(411775);

  typedef enum logic [4:0] {
    ST_IDLE, ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_Q5,
    ST_VEC_GO, ST_VEC_WAIT, ST_ROT_GO, ST_ROT_WAIT,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
    ST_D1, ST_D2, ST_D3, ST_D4,
    ST_A1, ST_A2, ST_L1, ST_L2, ST_OUT
  } state_t;

  // atan(2^-i) in 2^32 units per turn
  function automatic logic [31:0] atan_at(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // round a 32-bit turn angle to a 16-bit binary angle
  function automatic logic [15:0] angle16(input logic [31:0] a);
    logic [31:0] s;
    s = a + 32'h8000;
    return s[31:16];
  endfunction

  // wrapped heading error, half turn reads as +half turn
  function automatic logic signed [16:0] head_err(input logic [15:0] t, input logic [15:0] c);
    logic [15:0] d;
    d = t - c;
    if (d == 16'h8000) return 17'sd32768;
    return {d[15], d};
  endfunction

endpackage

/* hdl/fpc_mul.sv */
// Shared signed multiplier with a registered product
module fpc_mul (
  input  logic                           clk,
  input  logic signed [fpc_pkg::MW-1:0]  a,
  input  logic signed [fpc_pkg::MW-1:0]  b,
  output logic signed [fpc_pkg::PW-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

/* hdl/fpc_cordic.sv */
// Iterative CORDIC, vectoring or rotation, one micro-rotation per cycle
module fpc_cordic #(
  parameter int STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          vec_mode,
  input  logic signed [fpc_pkg::XW-1:0] x_in,
  input  logic signed [fpc_pkg::XW-1:0] y_in,
  input  logic [15:0]                   ang_in,
  output logic                          done,
  output logic signed [fpc_pkg::XW-1:0] x_out,
  output logic signed [fpc_pkg::XW-1:0] y_out,
  output logic [31:0]                   z_out
);

  localparam int IW = $clog2(STEPS);

  logic                          busy;
  logic                          vec;
  logic                          zero;
  logic                          neg;
  logic [IW-1:0]                 idx;
  logic signed [fpc_pkg::XW-1:0] x, y;
  logic signed [fpc_pkg::ZW-1:0] z;
  logic signed [fpc_pkg::XW-1:0] xs, ys;
  logic signed [fpc_pkg::ZW-1:0] tab;
  logic signed [fpc_pkg::ZW-1:0] zs;
  logic                          ccw;

  // micro-rotation terms
  always_comb begin
    xs  = x >>> idx;
    ys  = y >>> idx;
    tab = fpc_pkg::ZW'(fpc_pkg::atan_at(5'(idx)));
    ccw = vec ? !(y > 0) : (z >= 0);
    zs  = fpc_pkg::ZW'($signed(ang_in)) <<< 16;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        if (idx == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        idx <= idx + 1'b1;
      end
    end
  end

  // datapath: prepare on start, then iterate
  always_ff @(posedge clk) begin
    if (start) begin
      vec  <= vec_mode;
      zero <= vec_mode && (x_in == '0) && (y_in == '0);
      if (vec_mode) begin
        neg <= 1'b0;
        if (x_in < 0) begin
          x <= -x_in;
          y <= -y_in;
          z <= fpc_pkg::ZW'(64'sh80000000);
        end else begin
          x <= x_in;
          y <= y_in;
          z <= '0;
        end
      end else begin
        x <= fpc_pkg::INV_K_Q30;
        y <= '0;
        if (zs > fpc_pkg::ZW'(64'sh40000000)) begin
          z   <= zs - fpc_pkg::ZW'(64'sh80000000);
          neg <= 1'b1;
        end else if (zs < -fpc_pkg::ZW'(64'sh40000000)) begin
          z   <= zs + fpc_pkg::ZW'(64'sh80000000);
          neg <= 1'b1;
        end else begin
          z   <= zs;
          neg <= 1'b0;
        end
      end
    end else if (busy) begin
      if (ccw) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - tab;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + tab;
      end
    end
  end

  // result shaping
  always_comb begin
    if (vec) begin
      x_out = (zero || x < 0) ? '0 : x;
      y_out = y;
      z_out = zero ? 32'h0 : z[31:0];
    end else begin
      x_out = neg ? -x : x;
      y_out = neg ? -y : y;
      z_out = z[31:0];
    end
  end

endmodule

/* hdl/formation_pursuit_controller.sv */
// Formation pursuit controller: sequencer, state and shared arithmetic
// Pose item: quaternion products, then one vectoring CORDIC.
// Tick item: rotation CORDIC, offset products, vectoring CORDIC, distance and angular steps,
//   then linear steps unless aligning; waiting or stale ticks go straight to output.
// One item at a time; in_ready is high only while idle, again the cycle after a beat leaves.
// Synchronous reset clears poses, seen flags, tick counter and loads default registers.
`include "formation_pursuit_controller_assert.svh"
module formation_pursuit_controller #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        linear_cmd,
  output logic signed [15:0] angular_cmd,
  output logic [1:0]         mode,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int XW = fpc_pkg::XW;
  localparam int MW = fpc_pkg::MW;
  localparam int PW = fpc_pkg::PW;
  localparam int DW = fpc_pkg::DW;

  fpc_pkg::state_t state, state_next;

  // configuration registers
  logic signed [31:0] trail_ofs, lateral_ofs;
  logic [14:0]        max_linear, max_angular;
  logic [15:0]        gain_linear, gain_angular;
  logic [30:0]        arrive_distance;
  logic [15:0]        stale_ticks;

  // kept state
  logic signed [31:0] leader_x, leader_y, own_x, own_y;
  logic [15:0]        leader_hd, own_hd;
  logic               leader_seen, own_seen;
  logic [15:0]        tick_cnt, tick_cnt_inc;

  // item and work registers
  logic               is_leader, is_tick;
  logic signed [31:0] px, py;
  logic signed [15:0] qx, qy, qz, qw;
  logic signed [PW-1:0] acc;
  logic signed [XW-1:0] vec_x, vec_y;
  logic signed [MW-1:0] cc, ss;
  logic [31:0]          vang;
  logic [XW-1:0]        vmag;
  logic [DW-1:0]        slot_range;
  logic signed [16:0]   err;
  logic [14:0]          lin0;

  // shared units
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic                 cor_start, cor_vec, cor_done;
  logic signed [XW-1:0] cor_x, cor_y;
  logic [31:0]          cor_z;

  logic               accept;
  logic               ready_both, stale;
  logic               aligning;
  logic signed [16:0] err_sel;
  logic [16:0]        err_mag;
  logic [DW-1:0]      dist_calc;
  logic [31:0]        dist_sat;
  logic signed [PW-1:0] ang_raw, lin_raw;

  fpc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  fpc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .start    (cor_start),
    .vec_mode (cor_vec),
    .x_in     (vec_x),
    .y_in     (vec_y),
    .ang_in   (leader_hd),
    .done     (cor_done),
    .x_out    (cor_x),
    .y_out    (cor_y),
    .z_out    (cor_z)
  );

  assign in_ready  = (state == fpc_pkg::ST_IDLE);
  assign out_valid = (state == fpc_pkg::ST_OUT);
  assign accept    = in_valid && in_ready;

  // tick bookkeeping and decision terms
  always_comb begin
    tick_cnt_inc = (tick_cnt == 16'hFFFF) ? tick_cnt : tick_cnt + 16'd1;
    ready_both   = leader_seen && own_seen;
    stale        = tick_cnt_inc > stale_ticks;
    aligning     = slot_range < DW'(arrive_distance);
    err_sel      = aligning ? fpc_pkg::head_err(leader_hd, own_hd)
                            : fpc_pkg::head_err(fpc_pkg::angle16(vang), own_hd);
    err_mag      = err[16] ? 17'(-err) : 17'(err);
    dist_calc    = DW'(((prod <<< 20) + acc + (PW'(1) <<< 23)) >>> 24);
    dist_sat     = (slot_range[DW-1:32] != '0) ? 32'hFFFFFFFF : slot_range[31:0];
    ang_raw      = (prod + (PW'(1) <<< 27)) >>> 28;
    lin_raw      = (prod + PW'(2048)) >>> 12;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fpc_pkg::ST_IDLE: begin
        if (accept) begin
          case (action)
            fpc_pkg::ACT_LEADER, fpc_pkg::ACT_OWN: state_next = fpc_pkg::ST_Q1;
            fpc_pkg::ACT_TICK: begin
              if (!ready_both || stale) state_next = fpc_pkg::ST_OUT;
              else state_next = fpc_pkg::ST_ROT_GO;
            end
            default: state_next = fpc_pkg::ST_IDLE;
          endcase
        end
      end
      fpc_pkg::ST_Q1:       state_next = fpc_pkg::ST_Q2;
      fpc_pkg::ST_Q2:       state_next = fpc_pkg::ST_Q3;
      fpc_pkg::ST_Q3:       state_next = fpc_pkg::ST_Q4;
      fpc_pkg::ST_Q4:       state_next = fpc_pkg::ST_Q5;
      fpc_pkg::ST_Q5:       state_next = fpc_pkg::ST_VEC_GO;
      fpc_pkg::ST_VEC_GO:   state_next = fpc_pkg::ST_VEC_WAIT;
      fpc_pkg::ST_VEC_WAIT: begin
        if (cor_done) state_next = is_tick ? fpc_pkg::ST_D1 : fpc_pkg::ST_IDLE;
      end
      fpc_pkg::ST_ROT_GO:   state_next = fpc_pkg::ST_ROT_WAIT;
      fpc_pkg::ST_ROT_WAIT: begin
        if (cor_done) state_next = fpc_pkg::ST_M1;
      end
      fpc_pkg::ST_M1:       state_next = fpc_pkg::ST_M2;
      fpc_pkg::ST_M2:       state_next = fpc_pkg::ST_M3;
      fpc_pkg::ST_M3:       state_next = fpc_pkg::ST_M4;
      fpc_pkg::ST_M4:       state_next = fpc_pkg::ST_M5;
      fpc_pkg::ST_M5:       state_next = fpc_pkg::ST_VEC_GO;
      fpc_pkg::ST_D1:       state_next = fpc_pkg::ST_D2;
      fpc_pkg::ST_D2:       state_next = fpc_pkg::ST_D3;
      fpc_pkg::ST_D3:       state_next = fpc_pkg::ST_D4;
      fpc_pkg::ST_D4:       state_next = fpc_pkg::ST_A1;
      fpc_pkg::ST_A1:       state_next = fpc_pkg::ST_A2;
      fpc_pkg::ST_A2: begin
        state_next = (mode == fpc_pkg::MODE_ALIGN) ? fpc_pkg::ST_OUT : fpc_pkg::ST_L1;
      end
      fpc_pkg::ST_L1:       state_next = fpc_pkg::ST_L2;
      fpc_pkg::ST_L2:       state_next = fpc_pkg::ST_OUT;
      fpc_pkg::ST_OUT: begin
        if (out_ready) state_next = fpc_pkg::ST_IDLE;
      end
      default:              state_next = fpc_pkg::ST_IDLE;
    endcase
  end

  // unit controls and multiplier operands
  always_comb begin
    cor_start = (state == fpc_pkg::ST_VEC_GO) || (state == fpc_pkg::ST_ROT_GO);
    cor_vec   = (state == fpc_pkg::ST_VEC_GO);
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      fpc_pkg::ST_Q1: begin mul_a = MW'(qw); mul_b = MW'(qz); end
      fpc_pkg::ST_Q2: begin mul_a = MW'(qx); mul_b = MW'(qy); end
      fpc_pkg::ST_Q3: begin mul_a = MW'(qy); mul_b = MW'(qy); end
      fpc_pkg::ST_Q4: begin mul_a = MW'(qz); mul_b = MW'(qz); end
      fpc_pkg::ST_M1: begin mul_a = MW'(trail_ofs); mul_b = cc; end
      fpc_pkg::ST_M2: begin mul_a = MW'(lateral_ofs); mul_b = ss; end
      fpc_pkg::ST_M3: begin mul_a = MW'(trail_ofs); mul_b = ss; end
      fpc_pkg::ST_M4: begin mul_a = MW'(lateral_ofs); mul_b = cc; end
      fpc_pkg::ST_D1: begin
        mul_a = MW'({1'b0, vmag[19:0]});
        mul_b = fpc_pkg::INV_K_Q24;
      end
      fpc_pkg::ST_D2: begin
        mul_a = MW'({1'b0, vmag[XW-1:20]});
        mul_b = fpc_pkg::INV_K_Q24;
      end
      fpc_pkg::ST_D4: begin
        mul_a = MW'({1'b0, gain_angular});
        mul_b = MW'(err_sel);
      end
      fpc_pkg::ST_A1: begin mul_a = prod[MW-1:0]; mul_b = fpc_pkg::TWO_PI_Q16; end
      fpc_pkg::ST_A2: begin
        mul_a = MW'({1'b0, gain_linear});
        mul_b = MW'({1'b0, dist_sat});
      end
      fpc_pkg::ST_L1: begin
        mul_a = MW'({1'b0, (lin_raw > PW'(max_linear)) ? max_linear : lin_raw[14:0]});
        mul_b = MW'({1'b0, 17'd32768 - err_mag});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // state register, configuration and kept state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= fpc_pkg::ST_IDLE;
      trail_ofs       <= -32'sd196608;
      lateral_ofs     <= 32'sd163840;
      max_linear      <= 15'd4915;
      max_angular     <= 15'd6144;
      gain_linear     <= 16'd205;
      gain_angular    <= 16'd512;
      arrive_distance <= 31'd26214;
      stale_ticks     <= 16'd30;
      leader_x        <= '0;
      leader_y        <= '0;
      own_x           <= '0;
      own_y           <= '0;
      leader_hd       <= '0;
      own_hd          <= '0;
      leader_seen     <= 1'b0;
      own_seen        <= 1'b0;
      tick_cnt        <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          fpc_pkg::REG_TRAIL_OFS:   trail_ofs       <= cfg_data;
          fpc_pkg::REG_LATERAL_OFS: lateral_ofs     <= cfg_data;
          fpc_pkg::REG_MAX_LINEAR:  max_linear      <= cfg_data[14:0];
          fpc_pkg::REG_MAX_ANGULAR: max_angular     <= cfg_data[14:0];
          fpc_pkg::REG_GAIN_LINEAR: gain_linear     <= cfg_data[15:0];
          fpc_pkg::REG_GAIN_ANG:    gain_angular    <= cfg_data[15:0];
          fpc_pkg::REG_ARRIVE:      arrive_distance <= cfg_data[30:0];
          fpc_pkg::REG_STALE:       stale_ticks     <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (accept && action == fpc_pkg::ACT_TICK) tick_cnt <= tick_cnt_inc;
      // pose commit when its yaw is ready
      if (state == fpc_pkg::ST_VEC_WAIT && cor_done && !is_tick) begin
        if (is_leader) begin
          leader_x    <= px;
          leader_y    <= py;
          leader_hd   <= fpc_pkg::angle16(cor_z);
          leader_seen <= 1'b1;
          tick_cnt    <= '0;
        end else begin
          own_x    <= px;
          own_y    <= py;
          own_hd   <= fpc_pkg::angle16(cor_z);
          own_seen <= 1'b1;
        end
      end
    end
  end

  // work datapath
  always_ff @(posedge clk) begin
    case (state)
      fpc_pkg::ST_IDLE: begin
        if (accept) begin
          is_leader   <= (action == fpc_pkg::ACT_LEADER);
          is_tick     <= (action == fpc_pkg::ACT_TICK);
          px          <= pos_x;
          py          <= pos_y;
          qx          <= quat_x;
          qy          <= quat_y;
          qz          <= quat_z;
          qw          <= quat_w;
          linear_cmd  <= '0;
          angular_cmd <= '0;
          mode        <= !ready_both ? fpc_pkg::MODE_WAIT : fpc_pkg::MODE_STALE;
        end
      end
      fpc_pkg::ST_Q2: acc <= prod;
      fpc_pkg::ST_Q3: vec_y <= XW'((acc + prod) <<< 1);
      fpc_pkg::ST_Q4: acc <= prod;
      fpc_pkg::ST_Q5: vec_x <= (XW'(1) <<< 28) - XW'((acc + prod) <<< 1);
      fpc_pkg::ST_VEC_WAIT: begin
        vang <= cor_z;
        vmag <= cor_x;
      end
      fpc_pkg::ST_ROT_WAIT: begin
        cc <= cor_x[MW-1:0];
        ss <= cor_y[MW-1:0];
      end
      fpc_pkg::ST_M2: acc <= prod;
      fpc_pkg::ST_M3: begin
        vec_x <= XW'(leader_x) + XW'((acc - prod) >>> 30) - XW'(own_x);
      end
      fpc_pkg::ST_M4: acc <= prod;
      fpc_pkg::ST_M5: begin
        vec_y <= XW'(leader_y) + XW'((acc + prod) >>> 30) - XW'(own_y);
      end
      fpc_pkg::ST_D2: acc <= prod;
      fpc_pkg::ST_D3: slot_range <= dist_calc;
      fpc_pkg::ST_D4: begin
        err  <= err_sel;
        mode <= aligning ? fpc_pkg::MODE_ALIGN : fpc_pkg::MODE_PURSUE;
      end
      fpc_pkg::ST_A2: begin
        if (ang_raw > $signed(PW'(max_angular)))
          angular_cmd <= $signed({1'b0, max_angular});
        else if (ang_raw < -$signed(PW'(max_angular)))
          angular_cmd <= -$signed({1'b0, max_angular});
        else
          angular_cmd <= ang_raw[15:0];
      end
      fpc_pkg::ST_L1: lin0 <= (lin_raw > PW'(max_linear)) ? max_linear : lin_raw[14:0];
      fpc_pkg::ST_L2: linear_cmd <= 15'((prod + PW'(16384)) >>> 15);
      default: ;
    endcase
  end

  // checks
  `FPC_ASSERT_NOW(a_out_blocks_in, out_valid, !in_ready, "result pending while ready")
  `FPC_ASSERT_NOW(a_wait_zero, out_valid && mode == fpc_pkg::MODE_WAIT,
    linear_cmd == '0 && angular_cmd == '0, "waiting beat carries a command")
  `FPC_ASSERT_NOW(a_lin_pursue, out_valid && mode != fpc_pkg::MODE_PURSUE,
    linear_cmd == '0, "forward speed outside pursuit")
  `FPC_ASSERT_NOW(a_cordic_done, cor_done,
    state == fpc_pkg::ST_VEC_WAIT || state == fpc_pkg::ST_ROT_WAIT, "stray CORDIC done")
  `FPC_ASSERT_NEXT(a_lin_bound, state == fpc_pkg::ST_L1, lin0 <= max_linear,
    "speed clamp exceeded")

endmodule
